// File: sv/two_level_lru_cache_inclusion_policy_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-level cache tag core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_LRU_CACHE_INCLUSION_POLICY_CORE_MACROS_SVH
`define TWO_LEVEL_LRU_CACHE_INCLUSION_POLICY_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TLC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TLC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tlc_pkg.sv
// ---------------------------------------------------------------------------
// tlc_pkg
// Types, codes and default sizes shared by the two-level cache tag core.
// ---------------------------------------------------------------------------
`default_nettype none

package tlc_pkg;

  localparam int ADDR_BITS_DEF       = 48;
  localparam int FIRST_MAX_SETS_DEF  = 64;
  localparam int FIRST_MAX_WAYS_DEF  = 8;
  localparam int SECOND_MAX_SETS_DEF = 1024;
  localparam int SECOND_MAX_WAYS_DEF = 16;

  // Rebuilt victim addresses and stored tags keep the full 64-bit range.
  localparam int VADDR_W   = 64;
  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] MODE_INCL = 2'd0;
  localparam logic [1:0] MODE_NINE = 2'd1;
  localparam logic [1:0] MODE_EXCL = 2'd2;

  localparam logic [1:0] HIT_L1   = 2'd0;
  localparam logic [1:0] HIT_L2   = 2'd1;
  localparam logic [1:0] HIT_NONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_SETS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_SETS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS  = 3'd5;

  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_READ,
    LOP_LOOK,
    LOP_INV,
    LOP_SCAN,
    LOP_FILL
  } level_op_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic evict;
    logic ready;
  } level_status_t;

  typedef struct packed {
    level_status_t l1;
    level_status_t l2;
  } dp_status_t;

  typedef struct packed {
    level_op_t l1_op;
    level_op_t l2_op;
    logic      l1_vic;
    logic      l2_vic;
    logic      capture;
    logic      count_l1;
    logic      count_l2;
    logic      load_out;
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L1_RD,
    ST_L1_LOOK,
    ST_L2_RD,
    ST_L2_LOOK,
    ST_F2_RD,
    ST_F2_SCAN,
    ST_F2_WR,
    ST_I1_RD,
    ST_I1_INV,
    ST_I2_RD,
    ST_I2_INV,
    ST_F1_RD,
    ST_F1_SCAN,
    ST_F1_WR,
    ST_P2_RD,
    ST_P2_SCAN,
    ST_P2_WR,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// File: sv/tlc_level.sv
// ---------------------------------------------------------------------------
// tlc_level
// One set-associative tag level: row memories, lookup, invalidate and LRU fill.
// ---------------------------------------------------------------------------
`default_nettype none

module tlc_level #(
  parameter int MAX_SETS = tlc_pkg::FIRST_MAX_SETS_DEF,
  parameter int MAX_WAYS = tlc_pkg::FIRST_MAX_WAYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tlc_pkg::level_op_t                op,
  input  logic [tlc_pkg::VADDR_W-1:0]       addr,
  input  logic [3:0]                        off_bits,
  input  logic [3:0]                        set_bits_cfg,
  input  logic [4:0]                        ways_cfg,
  input  logic [tlc_pkg::STAMP_W-1:0]       stamp_now,
  output tlc_pkg::level_status_t            status,
  output logic [tlc_pkg::VADDR_W-1:0]       victim
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CW = $clog2(MAX_WAYS + 1);
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int AW     = tlc_pkg::VADDR_W;
  localparam int SW     = tlc_pkg::STAMP_W;

  logic [MAX_WAYS-1:0][AW-1:0] tag_mem   [MAX_SETS];
  logic [MAX_WAYS-1:0][SW-1:0] stamp_mem [MAX_SETS];
  logic [MAX_WAYS-1:0]         valid_mem [MAX_SETS];

  logic [MAX_WAYS-1:0][AW-1:0] row_tag, tag_new;
  logic [MAX_WAYS-1:0][SW-1:0] row_stamp, stamp_new;
  logic [MAX_WAYS-1:0]         row_valid, valid_new;
  logic [SET_W-1:0]            set_q, set_now;
  logic [AW-1:0]               tag_q, tag_now, blk, set_full;
  logic [WAY_IW-1:0]           pick, hit_way, empty_way, fill_way;
  logic [WAY_CW-1:0]           idx, ways_eff;
  logic [4:0]                  sb_eff;
  logic                        hit, has_empty, wr_en;
  logic                        clr_busy;
  logic [SET_W-1:0]            clr_cnt;

  // Effective geometry: set bits clamp to what the memory holds, ways to 1..MAX.
  always_comb begin
    sb_eff = ({1'b0, set_bits_cfg} > 5'(SB_MAX)) ? 5'(SB_MAX) : {1'b0, set_bits_cfg};
    if (ways_cfg == 5'd0) begin
      ways_eff = WAY_CW'(1);
    end else if ({1'b0, ways_cfg} > 6'(MAX_WAYS)) begin
      ways_eff = WAY_CW'(MAX_WAYS);
    end else begin
      ways_eff = WAY_CW'(ways_cfg);
    end
  end

  assign blk      = addr >> off_bits;
  assign set_full = blk & ((AW'(1) << sb_eff) - AW'(1));
  assign set_now  = set_full[SET_W-1:0];
  assign tag_now  = blk >> sb_eff;

  // Lowest matching way and lowest empty way among the ways in use.
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    has_empty = 1'b0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (WAY_CW'(w) < ways_eff) begin
        if (row_valid[w] && (row_tag[w] == tag_q)) begin
          hit     = 1'b1;
          hit_way = WAY_IW'(w);
        end
        if (!row_valid[w]) begin
          has_empty = 1'b1;
          empty_way = WAY_IW'(w);
        end
      end
    end
  end

  assign fill_way = has_empty ? empty_way : pick;
  assign victim   = ((row_tag[fill_way] << sb_eff) | AW'(set_q)) << off_bits;

  assign status.hit       = hit;
  assign status.scan_done = has_empty || (idx >= ways_eff);
  assign status.evict     = !has_empty;
  assign status.ready     = !clr_busy;

  always_comb begin
    tag_new   = row_tag;
    stamp_new = row_stamp;
    valid_new = row_valid;
    wr_en     = 1'b0;
    unique case (op)
      tlc_pkg::LOP_LOOK: begin
        stamp_new[hit_way] = stamp_now;
        wr_en              = hit;
      end
      tlc_pkg::LOP_INV: begin
        valid_new[hit_way] = 1'b0;
        wr_en              = hit;
      end
      tlc_pkg::LOP_FILL: begin
        tag_new[fill_way]   = tag_q;
        stamp_new[fill_way] = stamp_now;
        valid_new[fill_way] = 1'b1;
        wr_en               = 1'b1;
      end
      tlc_pkg::LOP_NONE, tlc_pkg::LOP_READ, tlc_pkg::LOP_SCAN: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Row read and one-way-per-cycle LRU scan.
  always_ff @(posedge clk) begin
    if (op == tlc_pkg::LOP_READ) begin
      row_tag   <= tag_mem[set_now];
      row_stamp <= stamp_mem[set_now];
      row_valid <= valid_mem[set_now];
      set_q     <= set_now;
      tag_q     <= tag_now;
      pick      <= '0;
      idx       <= WAY_CW'(1);
    end else if ((op == tlc_pkg::LOP_SCAN) && (idx < ways_eff)) begin
      if (row_stamp[idx[WAY_IW-1:0]] < row_stamp[pick]) begin
        pick <= idx[WAY_IW-1:0];
      end
      idx <= idx + WAY_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[set_q]   <= tag_new;
      stamp_mem[set_q] <= stamp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      valid_mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      valid_mem[set_q] <= valid_new;
    end
  end

  // Valid bits are swept to zero one row per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      if (clr_cnt == SET_W'(MAX_SETS - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/tlc_datapath.sv
// ---------------------------------------------------------------------------
// tlc_datapath
// Both tag levels, address and victim registers, counters and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tlc_datapath #(
  parameter int ADDR_BITS       = tlc_pkg::ADDR_BITS_DEF,
  parameter int FIRST_MAX_SETS  = tlc_pkg::FIRST_MAX_SETS_DEF,
  parameter int FIRST_MAX_WAYS  = tlc_pkg::FIRST_MAX_WAYS_DEF,
  parameter int SECOND_MAX_SETS = tlc_pkg::SECOND_MAX_SETS_DEF,
  parameter int SECOND_MAX_WAYS = tlc_pkg::SECOND_MAX_WAYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tlc_pkg::dp_cmd_t            cmd,
  output tlc_pkg::dp_status_t         status,
  input  logic [ADDR_BITS-1:0]        address,
  input  logic [3:0]                  block_offset_bits,
  input  logic [2:0]                  first_set_bits,
  input  logic [3:0]                  first_ways,
  input  logic [3:0]                  second_set_bits,
  input  logic [4:0]                  second_ways,
  output logic [1:0]                  hit_level,
  output logic [tlc_pkg::CNT_W-1:0]   first_hit_count,
  output logic [tlc_pkg::CNT_W-1:0]   first_miss_count,
  output logic [tlc_pkg::CNT_W-1:0]   second_hit_count,
  output logic [tlc_pkg::CNT_W-1:0]   second_miss_count
);

  localparam int AW = tlc_pkg::VADDR_W;
  localparam int CW = tlc_pkg::CNT_W;

  logic [AW-1:0]                 addr_q, vic_q, l1_addr, l2_addr, l1_victim, l2_victim;
  logic [tlc_pkg::STAMP_W-1:0]   access_clock;
  logic [CW-1:0]                 c_l1_hit, c_l1_miss, c_l2_hit, c_l2_miss;
  logic [1:0]                    hit_lvl;

  assign l1_addr = cmd.l1_vic ? vic_q : addr_q;
  assign l2_addr = cmd.l2_vic ? vic_q : addr_q;

  tlc_level #(
    .MAX_SETS (FIRST_MAX_SETS),
    .MAX_WAYS (FIRST_MAX_WAYS)
  ) u_l1 (
    .clk          (clk),
    .rst          (rst),
    .op           (cmd.l1_op),
    .addr         (l1_addr),
    .off_bits     (block_offset_bits),
    .set_bits_cfg ({1'b0, first_set_bits}),
    .ways_cfg     ({1'b0, first_ways}),
    .stamp_now    (access_clock),
    .status       (status.l1),
    .victim       (l1_victim)
  );

  tlc_level #(
    .MAX_SETS (SECOND_MAX_SETS),
    .MAX_WAYS (SECOND_MAX_WAYS)
  ) u_l2 (
    .clk          (clk),
    .rst          (rst),
    .op           (cmd.l2_op),
    .addr         (l2_addr),
    .off_bits     (block_offset_bits),
    .set_bits_cfg (second_set_bits),
    .ways_cfg     (second_ways),
    .stamp_now    (access_clock),
    .status       (status.l2),
    .victim       (l2_victim)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= AW'(address);
    end
    if (cmd.l1_op == tlc_pkg::LOP_FILL) begin
      vic_q <= l1_victim;
    end else if (cmd.l2_op == tlc_pkg::LOP_FILL) begin
      vic_q <= l2_victim;
    end
    if (cmd.count_l1) begin
      hit_lvl <= status.l1.hit ? tlc_pkg::HIT_L1 : hit_lvl;
    end else if (cmd.count_l2) begin
      hit_lvl <= status.l2.hit ? tlc_pkg::HIT_L2 : tlc_pkg::HIT_NONE;
    end
    if (cmd.load_out) begin
      hit_level         <= hit_lvl;
      first_hit_count   <= c_l1_hit;
      first_miss_count  <= c_l1_miss;
      second_hit_count  <= c_l2_hit;
      second_miss_count <= c_l2_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_l1_hit     <= '0;
      c_l1_miss    <= '0;
      c_l2_hit     <= '0;
      c_l2_miss    <= '0;
      access_clock <= '0;
    end else begin
      if (cmd.count_l1) begin
        if (status.l1.hit) begin
          c_l1_hit <= c_l1_hit + CW'(1);
        end else begin
          c_l1_miss <= c_l1_miss + CW'(1);
        end
      end
      if (cmd.count_l2) begin
        if (status.l2.hit) begin
          c_l2_hit <= c_l2_hit + CW'(1);
        end else begin
          c_l2_miss <= c_l2_miss + CW'(1);
        end
      end
      if (cmd.load_out) begin
        access_clock <= access_clock + tlc_pkg::STAMP_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/tlc_ctrl.sv
// ---------------------------------------------------------------------------
// tlc_ctrl
// Access sequencer: lookups, inclusion policy steps and result handoff.
// ---------------------------------------------------------------------------
`default_nettype none

module tlc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            inclusion_mode,
  input  tlc_pkg::dp_status_t   status,
  output tlc_pkg::dp_cmd_t      cmd
);

  tlc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlc_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.l1_op    = tlc_pkg::LOP_NONE;
    cmd.l2_op    = tlc_pkg::LOP_NONE;
    unique case (state)
      tlc_pkg::ST_CLEAR: begin
        if (status.l1.ready && status.l2.ready) begin
          state_next = tlc_pkg::ST_IDLE;
        end
      end
      tlc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = tlc_pkg::ST_L1_RD;
        end
      end
      tlc_pkg::ST_L1_RD: begin
        cmd.l1_op  = tlc_pkg::LOP_READ;
        state_next = tlc_pkg::ST_L1_LOOK;
      end
      tlc_pkg::ST_L1_LOOK: begin
        cmd.l1_op    = tlc_pkg::LOP_LOOK;
        cmd.count_l1 = 1'b1;
        state_next   = status.l1.hit ? tlc_pkg::ST_FIN : tlc_pkg::ST_L2_RD;
      end
      tlc_pkg::ST_L2_RD: begin
        cmd.l2_op  = tlc_pkg::LOP_READ;
        state_next = tlc_pkg::ST_L2_LOOK;
      end
      tlc_pkg::ST_L2_LOOK: begin
        cmd.l2_op    = tlc_pkg::LOP_LOOK;
        cmd.count_l2 = 1'b1;
        priority if (inclusion_mode == tlc_pkg::MODE_INCL ||
                     inclusion_mode == tlc_pkg::MODE_NINE) begin
          state_next = status.l2.hit ? tlc_pkg::ST_F1_RD : tlc_pkg::ST_F2_RD;
        end else if (inclusion_mode == tlc_pkg::MODE_EXCL) begin
          state_next = status.l2.hit ? tlc_pkg::ST_I2_RD : tlc_pkg::ST_F1_RD;
        end else begin
          state_next = tlc_pkg::ST_FIN;
        end
      end
      tlc_pkg::ST_F2_RD: begin
        cmd.l2_op  = tlc_pkg::LOP_READ;
        state_next = tlc_pkg::ST_F2_SCAN;
      end
      tlc_pkg::ST_F2_SCAN: begin
        if (status.l2.scan_done) begin
          state_next = tlc_pkg::ST_F2_WR;
        end else begin
          cmd.l2_op = tlc_pkg::LOP_SCAN;
        end
      end
      tlc_pkg::ST_F2_WR: begin
        cmd.l2_op = tlc_pkg::LOP_FILL;
        if (inclusion_mode == tlc_pkg::MODE_INCL && status.l2.evict) begin
          state_next = tlc_pkg::ST_I1_RD;
        end else begin
          state_next = tlc_pkg::ST_F1_RD;
        end
      end
      tlc_pkg::ST_I1_RD: begin
        cmd.l1_op  = tlc_pkg::LOP_READ;
        cmd.l1_vic = 1'b1;
        state_next = tlc_pkg::ST_I1_INV;
      end
      tlc_pkg::ST_I1_INV: begin
        cmd.l1_op  = tlc_pkg::LOP_INV;
        state_next = tlc_pkg::ST_F1_RD;
      end
      tlc_pkg::ST_I2_RD: begin
        cmd.l2_op  = tlc_pkg::LOP_READ;
        state_next = tlc_pkg::ST_I2_INV;
      end
      tlc_pkg::ST_I2_INV: begin
        cmd.l2_op  = tlc_pkg::LOP_INV;
        state_next = tlc_pkg::ST_F1_RD;
      end
      tlc_pkg::ST_F1_RD: begin
        cmd.l1_op  = tlc_pkg::LOP_READ;
        state_next = tlc_pkg::ST_F1_SCAN;
      end
      tlc_pkg::ST_F1_SCAN: begin
        if (status.l1.scan_done) begin
          state_next = tlc_pkg::ST_F1_WR;
        end else begin
          cmd.l1_op = tlc_pkg::LOP_SCAN;
        end
      end
      tlc_pkg::ST_F1_WR: begin
        cmd.l1_op = tlc_pkg::LOP_FILL;
        if (inclusion_mode == tlc_pkg::MODE_EXCL && status.l1.evict) begin
          state_next = tlc_pkg::ST_P2_RD;
        end else begin
          state_next = tlc_pkg::ST_FIN;
        end
      end
      tlc_pkg::ST_P2_RD: begin
        cmd.l2_op  = tlc_pkg::LOP_READ;
        cmd.l2_vic = 1'b1;
        state_next = tlc_pkg::ST_P2_SCAN;
      end
      tlc_pkg::ST_P2_SCAN: begin
        if (status.l2.scan_done) begin
          state_next = tlc_pkg::ST_P2_WR;
        end else begin
          cmd.l2_op = tlc_pkg::LOP_SCAN;
        end
      end
      tlc_pkg::ST_P2_WR: begin
        cmd.l2_op  = tlc_pkg::LOP_FILL;
        state_next = tlc_pkg::ST_FIN;
      end
      tlc_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = tlc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tlc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/two_level_lru_cache_inclusion_policy_core.sv
// ---------------------------------------------------------------------------
// two_level_lru_cache_inclusion_policy_core
// Tag side of a two-level set-associative LRU cache with selectable inclusion.
// ---------------------------------------------------------------------------
// Usage: one byte address is taken per transfer on the input channel
// (in_valid/in_ready/address). Each access produces exactly one transfer on
// the output channel (out_valid/out_ready) carrying the level that hit and
// the four running hit and miss counters after that access.
// Access sequence: an L1 hit reads the L1 row, looks the tag up and hands
// off the result. A miss adds a row read-and-update step per step of the
// policy, and each fill also chooses its way, comparing the stamps way by
// way when the set is full and needs an LRU victim. A new address is taken
// only once the previous access has finished its steps.
// The LRU search walks the stamps of one row one way per cycle, and each
// level has one row-wide memory port used for a read or a write per cycle.
// Reset: counters, access clock and control clear at once; then both levels
// sweep their valid bits one set per cycle until each has cleared all its
// sets, and in_ready stays low until both sweeps are done.
// Stall: a finished result waits in the output register; the core accepts
// the next address meanwhile and holds its next result until the first is
// taken. Configuration writes are taken in any cycle and must only be made
// while the core is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module two_level_lru_cache_inclusion_policy_core #(
  parameter int ADDR_BITS       = tlc_pkg::ADDR_BITS_DEF,
  parameter int FIRST_MAX_SETS  = tlc_pkg::FIRST_MAX_SETS_DEF,
  parameter int FIRST_MAX_WAYS  = tlc_pkg::FIRST_MAX_WAYS_DEF,
  parameter int SECOND_MAX_SETS = tlc_pkg::SECOND_MAX_SETS_DEF,
  parameter int SECOND_MAX_WAYS = tlc_pkg::SECOND_MAX_WAYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ADDR_BITS-1:0]              address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        hit_level,
  output logic [tlc_pkg::CNT_W-1:0]         first_hit_count,
  output logic [tlc_pkg::CNT_W-1:0]         first_miss_count,
  output logic [tlc_pkg::CNT_W-1:0]         second_hit_count,
  output logic [tlc_pkg::CNT_W-1:0]         second_miss_count,
  input  logic                              cfg_write,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlc_pkg::CFG_W-1:0]         cfg_data
);

  logic [1:0]          inclusion_mode;
  logic [3:0]          block_offset_bits;
  logic [2:0]          first_set_bits;
  logic [3:0]          first_ways;
  logic [3:0]          second_set_bits;
  logic [4:0]          second_ways;
  tlc_pkg::dp_cmd_t    cmd;
  tlc_pkg::dp_status_t status;

  // Configuration registers. Each write keeps the low bits of the data that
  // fit the register; indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      inclusion_mode    <= tlc_pkg::MODE_INCL;
      block_offset_bits <= 4'd6;
      first_set_bits    <= 3'd6;
      first_ways        <= 4'd8;
      second_set_bits   <= 4'd10;
      second_ways       <= 5'd16;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tlc_pkg::CFG_MODE:    inclusion_mode    <= cfg_data[1:0];
        tlc_pkg::CFG_OFFSET:  block_offset_bits <= cfg_data[3:0];
        tlc_pkg::CFG_L1_SETS: first_set_bits    <= cfg_data[2:0];
        tlc_pkg::CFG_L1_WAYS: first_ways        <= cfg_data[3:0];
        tlc_pkg::CFG_L2_SETS: second_set_bits   <= cfg_data[3:0];
        tlc_pkg::CFG_L2_WAYS: second_ways       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The sequencer decides the order of level operations; the datapath holds
  // the tag memories and all counters.
  tlc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .inclusion_mode (inclusion_mode),
    .status         (status),
    .cmd            (cmd)
  );

  tlc_datapath #(
    .ADDR_BITS       (ADDR_BITS),
    .FIRST_MAX_SETS  (FIRST_MAX_SETS),
    .FIRST_MAX_WAYS  (FIRST_MAX_WAYS),
    .SECOND_MAX_SETS (SECOND_MAX_SETS),
    .SECOND_MAX_WAYS (SECOND_MAX_WAYS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .address           (address),
    .block_offset_bits (block_offset_bits),
    .first_set_bits    (first_set_bits),
    .first_ways        (first_ways),
    .second_set_bits   (second_set_bits),
    .second_ways       (second_ways),
    .hit_level         (hit_level),
    .first_hit_count   (first_hit_count),
    .first_miss_count  (first_miss_count),
    .second_hit_count  (second_hit_count),
    .second_miss_count (second_miss_count)
  );

endmodule

`default_nettype wire

// File: sv/tlc_checker.sv
// ---------------------------------------------------------------------------
// tlc_checker
// Port-level checks on the cache tag core, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "two_level_lru_cache_inclusion_policy_core_macros.svh"

module tlc_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [1:0]                hit_level,
  input wire logic [tlc_pkg::CNT_W-1:0] first_miss_count,
  input wire logic [tlc_pkg::CNT_W-1:0] second_hit_count,
  input wire logic [tlc_pkg::CNT_W-1:0] second_miss_count
);

  // Every L1 miss is counted once as an L2 hit or an L2 miss.
  `TLC_ASSERT_SAME(a_l2_sum, out_valid, tlc_pkg::CNT_W'(second_hit_count + second_miss_count) == first_miss_count, "L2 counters disagree with L1 misses")

  // One access at a time: no second address right after a transfer.
  `TLC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "address taken while busy")

  // The valid-bit sweep keeps the input closed right after reset.
  `TLC_ASSERT_SAME(a_clear_after_reset, $fell(rst), !in_ready, "input open during clearing")

  // A stalled result holds.
  `TLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit_level) && $stable(first_miss_count), "result changed while stalled")

endmodule

bind two_level_lru_cache_inclusion_policy_core tlc_checker u_tlc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .hit_level         (hit_level),
  .first_miss_count  (first_miss_count),
  .second_hit_count  (second_hit_count),
  .second_miss_count (second_miss_count)
);

`default_nettype wire
